[hdl/assert_macros.svh]
// Assertion macros shared by the renderer RTL.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define SLAR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define SLAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/slar_pkg.sv]
// Types, constants and level tables for the status LED animation renderer.
// No dependencies.
`default_nettype none

package slar_pkg;

   typedef enum logic [2:0] {
      MODE_ERROR,
      MODE_PAIR,
      MODE_ANALOG,
      MODE_DIGITAL,
      MODE_IDLE
   } mode_type;

   localparam int unsigned ERR_PERIOD  = 6;
   localparam int unsigned ERR_ON      = 3;
   localparam int unsigned PAIR_PERIOD = 20;
   localparam int unsigned DIG_PERIOD  = 50;
   localparam int unsigned IDLE_PERIOD = 60;
   localparam int unsigned PAIR_HALF   = PAIR_PERIOD / 2;
   localparam int unsigned DIG_HALF    = DIG_PERIOD / 2;
   localparam int unsigned IDLE_HALF   = IDLE_PERIOD / 2;
   localparam int unsigned DIG_FLOOR   = 64;
   localparam int unsigned DIG_PEAK    = 160;
   localparam int unsigned IDLE_FLOOR  = 40;
   localparam int unsigned LVL_MAX     = 255;
   localparam int unsigned AMBER_GREEN = 120;

   // Common period of all animations; frame is first reduced modulo this.
   localparam int unsigned PHASE_PERIOD = 300;
   // floor(s / 300) = (s * MOD_RECIP) >> MOD_SHIFT for s < 2^17.
   localparam int unsigned MOD_RECIP    = 223697;
   localparam int unsigned MOD_SHIFT    = 26;
   // Byte weights of a 32-bit word modulo 300.
   localparam int unsigned W_BYTE2      = 136;
   localparam int unsigned W_BYTE3      = 16;
   // floor(p * 120 / 65025) = (p * AMBER_RECIP) >> AMBER_SHIFT for p <= 65025.
   localparam int unsigned AMBER_RECIP  = 990766;
   localparam int unsigned AMBER_SHIFT  = 29;

   typedef logic [PAIR_PERIOD-1:0][7:0] pair_tab_type;
   typedef logic [DIG_PERIOD-1:0][7:0]  dig_tab_type;
   typedef logic [IDLE_PERIOD-1:0][7:0] idle_tab_type;

   function automatic pair_tab_type build_pair_tab();
      pair_tab_type t;
      for (int y = 0; y < PAIR_PERIOD; y++) begin
         if (y < PAIR_HALF) t[y] = 8'(y * LVL_MAX / PAIR_HALF);
         else t[y] = 8'(LVL_MAX - (y - PAIR_HALF) * LVL_MAX / PAIR_HALF);
      end
      return t;
   endfunction

   function automatic dig_tab_type build_dig_tab();
      dig_tab_type t;
      int          tri_v;
      for (int y = 0; y < DIG_PERIOD; y++) begin
         if (y < DIG_HALF) tri_v = y * LVL_MAX / DIG_HALF;
         else tri_v = LVL_MAX - (y - DIG_HALF) * LVL_MAX / DIG_HALF;
         t[y] = 8'(DIG_FLOOR + tri_v * (DIG_PEAK - DIG_FLOOR) / LVL_MAX);
      end
      return t;
   endfunction

   function automatic idle_tab_type build_idle_tab();
      idle_tab_type t;
      int           tri_v;
      for (int y = 0; y < IDLE_PERIOD; y++) begin
         if (y < IDLE_HALF) tri_v = y * LVL_MAX / IDLE_HALF;
         else tri_v = LVL_MAX - (y - IDLE_HALF) * LVL_MAX / IDLE_HALF;
         t[y] = 8'(IDLE_FLOOR + tri_v * (LVL_MAX - IDLE_FLOOR) / LVL_MAX);
      end
      return t;
   endfunction

   localparam pair_tab_type PAIR_TAB = build_pair_tab();
   localparam dig_tab_type  DIG_TAB  = build_dig_tab();
   localparam idle_tab_type IDLE_TAB = build_idle_tab();

endpackage

`default_nettype wire

[hdl/slar_phase.sv]
// Three-stage reduction of the 32-bit frame number modulo 300.
// Uses slar_pkg constants.
`default_nettype none

module slar_phase (
   input  wire logic        clock,
   input  wire logic [2:0]  adv,       // per-stage load enables
   input  wire logic [31:0] frame,
   output logic      [8:0]  phase      // frame mod 300
);

   logic [16:0] sum_in, sum_ff, sum2_ff;
   logic [34:0] prod;
   logic [8:0]  quo_in, quo_ff;
   logic [16:0] rem_full;
   logic [8:0]  phase_in, phase_ff;

   // stage 1: fold bytes with their weights mod 300 (max 104295)
   always_comb begin
      sum_in = 17'({frame[31:24], 4'b0})
             + 17'(frame[23:16]) * 17'(slar_pkg::W_BYTE2)
             + 17'({frame[15:8], 8'b0})
             + 17'(frame[7:0]);
   end

   // stage 2: quotient by reciprocal
   always_comb begin
      prod   = 35'(sum_ff) * 35'(slar_pkg::MOD_RECIP);
      quo_in = prod[slar_pkg::MOD_SHIFT +: 9];
   end

   // stage 3: remainder
   always_comb begin
      rem_full = sum2_ff - 17'(quo_ff) * 17'(slar_pkg::PHASE_PERIOD);
      phase_in = rem_full[8:0];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) sum_ff <= sum_in;
      if (adv[1]) begin
         sum2_ff <= sum_ff;
         quo_ff  <= quo_in;
      end
      if (adv[2]) phase_ff <= phase_in;
   end

   assign phase = phase_ff;

endmodule

`default_nettype wire

[hdl/status_led_animation_renderer.sv]
// Status LED animation renderer, top level: six-stage pipeline from flags
// and frame number to one RGB beat. Uses slar_pkg, slar_phase, assert_macros.svh.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   req      | req_valid / req_ready  | error, pairing, connected, analog, frame
//   rsp      | rsp_valid / rsp_ready  | red, green, blue
//   csr      | csr_wr_en (no wait)    | csr_wr_data = max_brightness
//
// One beat enters per cycle unless stalled; rsp_valid is the stage-6 valid bit.
// Throughput is set by the per-stage valid/ready chain: every stage holds one beat.
// Stalls back up stage by stage; a stage refills as soon as its successor moves.
// Reset (synchronous) empties the pipeline and sets max_brightness to 255.
`default_nettype none

module status_led_animation_renderer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_error_flag,
   input  wire logic        req_pairing_flag,
   input  wire logic        req_connected_flag,
   input  wire logic        req_analog_flag,
   input  wire logic [31:0] req_frame_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_red,
   output logic      [7:0]  rsp_green,
   output logic      [7:0]  rsp_blue,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

`include "assert_macros.svh"

   localparam int unsigned NSTG = 6;

   // ---- control: valid bits travel with the data ----
   logic [NSTG-1:0] vld_ff, vld_in;
   logic [NSTG:0]   rdy;     // rdy[i]: stage i may load this cycle

   always_comb begin
      rdy[NSTG] = rsp_ready;
      for (int i = NSTG - 1; i >= 0; i--) rdy[i] = !vld_ff[i] || rdy[i+1];
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NSTG; i++) vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= vld_in;
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NSTG-1];

   // ---- brightness register ----
   logic [7:0] max_ff;
   always_ff @(posedge clock) begin
      if (reset) max_ff <= 8'd255;
      else if (csr_wr_en) max_ff <= csr_wr_data;
   end

   // ---- stages 1..3: mode decode, frame mod 300 ----
   slar_pkg::mode_type mode_in, mode1_ff, mode2_ff, mode3_ff, mode4_ff, mode5_ff;
   logic [8:0] phase;

   // priority: error > pairing > connected (analog/digital) > idle
   always_comb begin
      if (req_error_flag) mode_in = slar_pkg::MODE_ERROR;
      else if (req_pairing_flag) mode_in = slar_pkg::MODE_PAIR;
      else if (req_connected_flag && req_analog_flag) mode_in = slar_pkg::MODE_ANALOG;
      else if (req_connected_flag) mode_in = slar_pkg::MODE_DIGITAL;
      else mode_in = slar_pkg::MODE_IDLE;
   end

   slar_phase u_phase (
      .clock (clock),
      .adv   (rdy[2:0]),
      .frame (req_frame_count),
      .phase (phase)
   );

   // ---- stage 4: sub-periods and animation level ----
   logic [2:0] q60, q50;
   logic [3:0] q6;
   logic [1:0] q20;
   logic [5:0] r60, r50;
   logic [4:0] r20;
   logic [2:0] r6;
   logic [7:0] level_in, level_ff;

   always_comb begin
      q60 = '0;
      for (int k = 1; k < slar_pkg::PHASE_PERIOD / slar_pkg::IDLE_PERIOD; k++)
         if (phase >= 9'(k * slar_pkg::IDLE_PERIOD)) q60 = 3'(k);
      r60 = 6'(phase - 9'(q60) * 9'(slar_pkg::IDLE_PERIOD));

      q50 = '0;
      for (int k = 1; k < slar_pkg::PHASE_PERIOD / slar_pkg::DIG_PERIOD; k++)
         if (phase >= 9'(k * slar_pkg::DIG_PERIOD)) q50 = 3'(k);
      r50 = 6'(phase - 9'(q50) * 9'(slar_pkg::DIG_PERIOD));

      // 6 and 20 both divide 60
      q6 = '0;
      for (int k = 1; k < slar_pkg::IDLE_PERIOD / slar_pkg::ERR_PERIOD; k++)
         if (r60 >= 6'(k * slar_pkg::ERR_PERIOD)) q6 = 4'(k);
      r6 = 3'(r60 - 6'(q6) * 6'(slar_pkg::ERR_PERIOD));

      q20 = '0;
      for (int k = 1; k < slar_pkg::IDLE_PERIOD / slar_pkg::PAIR_PERIOD; k++)
         if (r60 >= 6'(k * slar_pkg::PAIR_PERIOD)) q20 = 2'(k);
      r20 = 5'(r60 - 6'(q20) * 6'(slar_pkg::PAIR_PERIOD));
   end

   always_comb begin
      unique case (mode3_ff)
         slar_pkg::MODE_ERROR:   level_in = (r6 < 3'(slar_pkg::ERR_ON)) ? 8'd255 : 8'd0;
         slar_pkg::MODE_PAIR:    level_in = slar_pkg::PAIR_TAB[r20];
         slar_pkg::MODE_ANALOG:  level_in = 8'd255;
         slar_pkg::MODE_DIGITAL: level_in = slar_pkg::DIG_TAB[r50];
         slar_pkg::MODE_IDLE:    level_in = slar_pkg::IDLE_TAB[r60];
         default:                level_in = 8'd0;
      endcase
   end

   // ---- stage 5: level * brightness ----
   logic [15:0] scale_in, scale_ff;
   assign scale_in = 16'(level_ff) * 16'(max_ff);

   // ---- stage 6: divide by 65025 per hue, output register ----
   // Full-hue channels: scale / 255, exact below 65280.
   // Amber green (hue 120): reciprocal multiply.
   logic [16:0] div_sum;
   logic [7:0]  full_ch, amber_g;
   logic [35:0] amber_prod;
   logic [7:0]  red_in, green_in, blue_in;
   logic [7:0]  red_ff, green_ff, blue_ff;

   always_comb begin
      div_sum    = 17'(scale_ff) + 17'd1 + 17'(scale_ff[15:8]);
      full_ch    = div_sum[15:8];
      amber_prod = 36'(scale_ff) * 36'(slar_pkg::AMBER_RECIP);
      amber_g    = 8'(amber_prod >> slar_pkg::AMBER_SHIFT);
   end

   always_comb begin
      red_in   = 8'd0;
      green_in = 8'd0;
      blue_in  = 8'd0;
      unique case (mode5_ff) inside
         slar_pkg::MODE_ERROR: red_in = full_ch;
         slar_pkg::MODE_PAIR:  blue_in = full_ch;
         slar_pkg::MODE_ANALOG, slar_pkg::MODE_DIGITAL: green_in = full_ch;
         slar_pkg::MODE_IDLE: begin
            red_in   = full_ch;
            green_in = amber_g;
         end
         default: red_in = 8'd0;
      endcase
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (rdy[0]) mode1_ff <= mode_in;
      if (rdy[1]) mode2_ff <= mode1_ff;
      if (rdy[2]) mode3_ff <= mode2_ff;
      if (rdy[3]) begin
         mode4_ff <= mode3_ff;
         level_ff <= level_in;
      end
      if (rdy[4]) begin
         mode5_ff <= mode4_ff;
         scale_ff <= scale_in;
      end
      if (rdy[5]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // ---- checks ----
   `SLAR_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> vld_ff == '0, "pipeline not empty after reset")
   `SLAR_ASSERT(a_phase_range, clock, reset, vld_ff[3] |-> phase < 9'(slar_pkg::PHASE_PERIOD), "phase out of range")
   `SLAR_ASSERT(a_blue_alone, clock, reset, rsp_valid |-> (rsp_blue == 8'd0 || (rsp_red == 8'd0 && rsp_green == 8'd0)), "blue mixed with other channels")
   `SLAR_ASSERT(a_amber_ratio, clock, reset, (vld_ff[4] && rdy[5] && mode5_ff == slar_pkg::MODE_IDLE) |=> rsp_green <= rsp_red, "amber green above red")

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for status_led_animation_renderer: flags and frame number in, one RGB beat out.
// Depends on slar_pkg (mode_type, animation periods) and on the renderer RTL; the color predictor is local.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Product of the two 8-bit full scales; every channel is divided by it.
   localparam int unsigned FULL_SCALE   = 255 * 255;
   // Cycles the receiver holds off during the backpressure phase.
   localparam int          HOLD_CYCLES  = 400;
   // Pipeline depth is six; a little extra before calling the block empty.
   localparam int          SETTLE_CYCLES = 10;

   typedef struct {
      bit        error_flag;
      bit        pairing_flag;
      bit        connected_flag;
      bit        analog_flag;
      bit [31:0] frame_count;
   } status_beat_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_beat_type;

   // Expected colors, in order of acceptance, plus the brightness they are scaled by.
   class color_tracker_type;
      bit [7:0]     brightness;
      rgb_beat_type expected_colors[$];
      int           mismatches;

      function new();
         brightness = 8'd255;
         mismatches = 0;
      endfunction

      // Triangle wave: rises from 0 over the first half period, is 255 at the midpoint, then falls back.
      function int unsigned tri_wave(int unsigned x, int unsigned period);
         int unsigned half;
         int unsigned pos;
         half = period / 2;
         pos  = x % period;
         if (pos < half) return pos * 255 / half;
         return 255 - (pos - half) * 255 / half;
      endfunction

      function bit [7:0] scale_channel(int unsigned hue, int unsigned level);
         return 8'((hue * level * brightness) / FULL_SCALE);
      endfunction

      function rgb_beat_type render_color(status_beat_type s);
         slar_pkg::mode_type mode;
         int unsigned        level;
         int unsigned        hue_r, hue_g, hue_b;
         rgb_beat_type       c;
         if (s.error_flag) mode = slar_pkg::MODE_ERROR;
         else if (s.pairing_flag) mode = slar_pkg::MODE_PAIR;
         else if (s.connected_flag && s.analog_flag) mode = slar_pkg::MODE_ANALOG;
         else if (s.connected_flag) mode = slar_pkg::MODE_DIGITAL;
         else mode = slar_pkg::MODE_IDLE;
         hue_r = 0;
         hue_g = 0;
         hue_b = 0;
         case (mode)
            slar_pkg::MODE_ERROR: begin
               hue_r = 255;
               level = ((s.frame_count % slar_pkg::ERR_PERIOD) < slar_pkg::ERR_ON) ? 255 : 0;
            end
            slar_pkg::MODE_PAIR: begin
               hue_b = 255;
               level = tri_wave(s.frame_count, slar_pkg::PAIR_PERIOD);
            end
            slar_pkg::MODE_ANALOG: begin
               hue_g = 255;
               level = 255;
            end
            slar_pkg::MODE_DIGITAL: begin
               hue_g = 255;
               level = slar_pkg::DIG_FLOOR
                     + tri_wave(s.frame_count, slar_pkg::DIG_PERIOD)
                     * (slar_pkg::DIG_PEAK - slar_pkg::DIG_FLOOR) / 255;
            end
            default: begin
               hue_r = 255;
               hue_g = 120;
               level = slar_pkg::IDLE_FLOOR
                     + tri_wave(s.frame_count, slar_pkg::IDLE_PERIOD)
                     * (255 - slar_pkg::IDLE_FLOOR) / 255;
            end
         endcase
         c.red   = scale_channel(hue_r, level);
         c.green = scale_channel(hue_g, level);
         c.blue  = scale_channel(hue_b, level);
         return c;
      endfunction

      function void note_request(status_beat_type s);
         expected_colors.push_back(render_color(s));
      endfunction

      function void report(string what, logic [7:0] exp_v, logic [7:0] act_v);
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
      endfunction

      function void check_color(rgb_beat_type got);
         rgb_beat_type want;
         if (expected_colors.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected rsp beat, expected none, got r=%0d g=%0d b=%0d",
                     $time, got.red, got.green, got.blue);
            return;
         end
         want = expected_colors.pop_front();
         if (got.red !== want.red) report("red", want.red, got.red);
         if (got.green !== want.green) report("green", want.green, got.green);
         if (got.blue !== want.blue) report("blue", want.blue, got.blue);
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset and every block input start at known values.
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_error_flag = 1'b0;
   logic        req_pairing_flag = 1'b0;
   logic        req_connected_flag = 1'b0;
   logic        req_analog_flag = 1'b0;
   logic [31:0] req_frame_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   // Idle knobs, in percent. The sender's is private to the stimulus process;
   // the receiver's is handed over by nonblocking assignment.
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          pressure_arm = 1'b0;
   bit          pressure_done = 1'b0;
   int          hold_left = 0;

   color_tracker_type tracker = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   status_led_animation_renderer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_error_flag     (req_error_flag),
      .req_pairing_flag   (req_pairing_flag),
      .req_connected_flag (req_connected_flag),
      .req_analog_flag    (req_analog_flag),
      .req_frame_count    (req_frame_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off counted here once the
   // stimulus arms it, so the pipeline fills and req_ready drops.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (pressure_arm && !pressure_done) begin
         pressure_done <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         rsp_ready     <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: values read right after the edge are the ones the edge saw,
   // since every driver here and in the block updates by nonblocking assignment.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_request('{req_error_flag, req_pairing_flag, req_connected_flag,
                                   req_analog_flag, req_frame_count});
         if (rsp_valid && rsp_ready)
            tracker.check_color('{rsp_red, rsp_green, rsp_blue});
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus tasks
   // ---------------------------------------------------------------------

   // Offer one beat and return at the edge that takes it. A gap, if any,
   // comes first, so valid is never dropped and raised in the same step.
   task automatic send_beat(input status_beat_type s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_error_flag     <= s.error_flag;
      req_pairing_flag   <= s.pairing_flag;
      req_connected_flag <= s.connected_flag;
      req_analog_flag    <= s.analog_flag;
      req_frame_count    <= s.frame_count;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_flags(input bit e, input bit p, input bit c, input bit a,
                             input bit [31:0] f);
      send_beat('{e, p, c, a, f});
   endtask

   // Let every outstanding beat come back, then give the pipe a few more edges.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_brightness(input bit [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.brightness = value;
   endtask

   // Mostly well-formed mode selections with random lower-priority flags;
   // a fifth are raw random flags. Frames near zero, near wrap, or anywhere.
   function automatic status_beat_type random_status();
      status_beat_type    s;
      slar_pkg::mode_type m;
      int                 frame_sel;
      s.error_flag     = 1'($urandom);
      s.pairing_flag   = 1'($urandom);
      s.connected_flag = 1'($urandom);
      s.analog_flag    = 1'($urandom);
      if ($urandom_range(4) != 0) begin
         m = slar_pkg::mode_type'($urandom_range(4));
         case (m)
            slar_pkg::MODE_ERROR: s.error_flag = 1'b1;
            slar_pkg::MODE_PAIR: begin
               s.error_flag   = 1'b0;
               s.pairing_flag = 1'b1;
            end
            slar_pkg::MODE_ANALOG: begin
               s.error_flag     = 1'b0;
               s.pairing_flag   = 1'b0;
               s.connected_flag = 1'b1;
               s.analog_flag    = 1'b1;
            end
            slar_pkg::MODE_DIGITAL: begin
               s.error_flag     = 1'b0;
               s.pairing_flag   = 1'b0;
               s.connected_flag = 1'b1;
               s.analog_flag    = 1'b0;
            end
            default: begin
               s.error_flag     = 1'b0;
               s.pairing_flag   = 1'b0;
               s.connected_flag = 1'b0;
            end
         endcase
      end
      frame_sel = $urandom_range(3);
      if (frame_sel == 0) s.frame_count = $urandom_range(599);
      else if (frame_sel == 3) s.frame_count = 32'hFFFF_FFFF - $urandom_range(599);
      else s.frame_count = $urandom;
      return s;
   endfunction

   task automatic send_random_beats(input int count);
      repeat (count) send_beat(random_status());
   endtask

   // One phase: settle, set brightness, set idle rates, push random beats.
   task automatic run_phase(input bit [7:0] level, input int idle_pct, input int stall,
                            input int count);
      drain_pipeline();
      write_brightness(level);
      send_idle_pct = idle_pct;
      stall_pct <= stall;
      send_random_beats(count);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at reset brightness, no idling on either side.
      // Error blink: on for frames 0..2 of each six; lower flags must not matter.
      send_flags(1, 1, 1, 1, 0);
      send_flags(1, 0, 0, 0, 1);
      send_flags(1, 1, 0, 1, 2);
      send_flags(1, 0, 1, 0, 3);
      send_flags(1, 1, 1, 0, 4);
      send_flags(1, 0, 0, 1, 5);
      send_flags(1, 0, 0, 0, 32'hFFFF_FFFF);
      // Pairing ramp: bottom, middle, peak, falling, last step, top of frame range.
      send_flags(0, 1, 1, 1, 0);
      send_flags(0, 1, 0, 0, 5);
      send_flags(0, 1, 1, 0, 10);
      send_flags(0, 1, 0, 1, 15);
      send_flags(0, 1, 0, 0, 19);
      send_flags(0, 1, 0, 0, 32'hFFFF_FFFF);
      // Analog is steady; analog without a connection falls back to idle.
      send_flags(0, 0, 1, 1, 32'h8000_0000);
      send_flags(0, 0, 0, 1, 0);
      // Digital breathing: floor, peak, end of period, wrap.
      send_flags(0, 0, 1, 0, 0);
      send_flags(0, 0, 1, 0, 25);
      send_flags(0, 0, 1, 0, 49);
      send_flags(0, 0, 1, 0, 32'hFFFF_FFFF);
      // Idle amber: first rising step, peak, end of period, wrap.
      send_flags(0, 0, 0, 0, 1);
      send_flags(0, 0, 0, 0, 30);
      send_flags(0, 0, 0, 0, 59);
      send_flags(0, 0, 0, 0, 32'hFFFF_FFFF);
      send_random_beats(300);

      // Zero brightness blanks every channel; both sides idle a little.
      run_phase(8'd0, 18, 18, 100);
      // Dimmest nonzero setting with a mostly idle sender.
      run_phase(8'd1, 88, 0, 300);
      // Random mid brightness with a mostly stalled receiver.
      run_phase(8'($urandom_range(2, 254)), 0, 88, 300);

      // Backpressure: receiver holds off for a long stretch while the
      // sender keeps offering, so the block fills and stalls its input.
      drain_pipeline();
      write_brightness(8'd128);
      send_idle_pct = 0;
      stall_pct    <= 0;
      pressure_arm <= 1'b1;
      send_random_beats(300);

      // Back to full scale, both sides idling now and then.
      run_phase(8'd255, 18, 18, 300);

      drain_pipeline();
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of about 1600 beats.
   initial begin
      #5ms;
      $display("tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
